// ===== design/mlt_pkg.sv =====
// mlt_pkg: shared types and constants for the motion light timeout block.
// No dependencies; imported by every module under design/.
package mlt_pkg;

    // Field widths
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned MINUTE_W  = 11;
    localparam int unsigned TIMEOUT_W = 10;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 11;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 8;

    // Request kinds (code 3 is unused and does nothing)
    localparam logic [REQ_W-1:0] REQ_RISE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FALL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    // Light commands
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STOP  = 2'd2;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 10'd5;
    localparam logic [MINUTE_W-1:0]  WINDOW_START_RST = 11'd420;
    localparam logic [MINUTE_W-1:0]  WINDOW_STOP_RST  = 11'd1320;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_minutes;
        logic [MINUTE_W-1:0]  window_start_minute;
        logic [MINUTE_W-1:0]  window_stop_minute;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic                sensor_level;
        logic [MINUTE_W-1:0] minute_of_day;
    } item_t;

    typedef struct packed {
        cmd_t light_cmd;
        logic final_on;
    } result_t;

endpackage

// ===== design/mlt_cfg.sv =====
// mlt_cfg: configuration registers (timeout and active window).
// Depends on mlt_pkg.
module mlt_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlt_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output mlt_pkg::cfg_t                  cfg
);
    import mlt_pkg::*;

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_minutes     <= TIMEOUT_RST;
            cfg_reg.window_start_minute <= WINDOW_START_RST;
            cfg_reg.window_stop_minute  <= WINDOW_STOP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT:      cfg_reg.timeout_minutes     <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_WINDOW_START: cfg_reg.window_start_minute <= cfg_wdata[MINUTE_W-1:0];
                CFG_WINDOW_STOP:  cfg_reg.window_stop_minute  <= cfg_wdata[MINUTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/mlt_step.sv =====
// mlt_step: timer state and the per-event decision logic.
// Depends on mlt_pkg. State advances only on cycles where step_en is high.
module mlt_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  mlt_pkg::item_t    item,
    input  mlt_pkg::cfg_t     cfg,
    output mlt_pkg::result_t  result
);
    import mlt_pkg::*;

    logic [TIMEOUT_W-1:0] remaining_reg, remaining_next;
    logic                 active_reg, active_next;
    logic                 armed_reg, armed_next;
    logic                 in_window;

    // Strict window test; empty when start >= stop
    assign in_window = (item.minute_of_day > cfg.window_start_minute) &&
                       (item.minute_of_day < cfg.window_stop_minute);

    // Next state and result for the event at the stage head
    always_comb begin
        remaining_next  = remaining_reg;
        active_next     = active_reg;
        armed_next      = armed_reg;
        result.light_cmd = CMD_NONE;
        result.final_on  = 1'b0;
        case (item.req_type)
            REQ_RISE: begin
                if (!active_reg) begin
                    if (in_window) begin
                        armed_next       = 1'b1;
                        result.light_cmd = CMD_ON;
                    end else if (armed_reg) begin
                        armed_next       = 1'b0;
                        result.light_cmd = CMD_ON;
                        result.final_on  = 1'b1;
                    end
                end
                active_next    = 1'b0;
                remaining_next = '0;
            end
            REQ_FALL: begin
                active_next    = 1'b1;
                remaining_next = cfg.timeout_minutes;
            end
            REQ_TICK: begin
                if (active_reg) begin
                    if (remaining_reg <= TIMEOUT_W'(1)) begin
                        active_next    = 1'b0;
                        remaining_next = '0;
                        if (!item.sensor_level && (in_window || armed_reg))
                            result.light_cmd = CMD_OFF;
                    end else begin
                        remaining_next = remaining_reg - TIMEOUT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            active_reg    <= 1'b0;
            armed_reg     <= 1'b1;
        end else if (step_en) begin
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

// ===== design/motion_light_timeout_top.sv =====
// motion_light_timeout_top: motion-sensor light controller with timeout.
// Depends on mlt_pkg, mlt_cfg and mlt_step.
//
//   channel | direction | carries
//   --------+-----------+------------------------------------------------
//   s_      | in        | event: kind in tuser, level and minute in tdata
//   m_      | out       | light command and final-on flag in tdata
//   cfg_    | in        | register writes, no read-back
//
// One event per cycle unless the output stalls. A transfer lands in the
// input register, the decision logic evaluates it combinationally and the
// result register takes it. A stalled result register holds the input
// stage; the input register still accepts while it is empty or draining.
// Reset is synchronous, active low, and clears both stages and timer state.
module motion_light_timeout_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [0] sensor_level, [11:1] minute_of_day, [15:12] zero
    input  logic [mlt_pkg::S_DATA_W-1:0]        s_tdata,
    // [1:0] req_type
    input  logic [mlt_pkg::REQ_W-1:0]           s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] light_cmd, [2] final_on, [7:3] zero
    output logic [mlt_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [mlt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlt_pkg::CFG_DAT_W-1:0]       cfg_wdata
);
    import mlt_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_result_reg;
    result_t step_result;
    logic    out_valid_reg;
    logic    out_free;
    logic    step_en;

    mlt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake between stages
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.req_type      <= s_tuser;
            in_item_reg.sensor_level  <= s_tdata[0];
            in_item_reg.minute_of_day <= s_tdata[MINUTE_W:1];
        end
    end

    mlt_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - CMD_W - 1)'(0), out_result_reg.final_on,
                       out_result_reg.light_cmd};

endmodule
